/* sv/prq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared widths, codes and controller command type for the rank queue.
// ----------------------------------------------------------------------------
package prq_pkg;

	localparam int RANK_W    = 27;
	localparam int HANDLE_W  = 16;
	localparam int OCC_W     = 6;
	localparam int CNT32_W   = 32;
	localparam int KIND_W    = 2;
	localparam int HL_W      = 5;

	localparam int DEPTH_DEFAULT = 32;
	localparam logic [RANK_W-1:0] EMPTY_SENTINEL_DEFAULT = RANK_W'(99999999);
	localparam logic [HL_W-1:0]   HIGH_LIMIT_RESET       = HL_W'(15);

	// stream payload widths
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 184;
	localparam int M_TUSER_W = KIND_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = HL_W;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_UPDATE = 1'b1;

	// opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EVICT = 2'd2;

	typedef struct packed {
		logic latch;
		logic exec;
		logic trim;
		logic load_out;
	} prq_cmd_t;

endpackage

/* sv/prq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer: accept an item, run insert or remove, trim the tail, emit result.
// ----------------------------------------------------------------------------
module prq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output prq_pkg::prq_cmd_t  cmd
);
	import prq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_TRIM = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   load;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign load     = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_EXEC;
			end
			ST_EXEC: state_nxt = ST_TRIM;
			ST_TRIM: state_nxt = ST_FIN;
			ST_FIN: begin
				if (load) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.latch    = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.trim     = (state_q == ST_TRIM);
		cmd.load_out = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/prq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_dp
// Sorted row of rank cells with parallel compare, shift, tail select,
// counters, configuration registers and result register.
// ----------------------------------------------------------------------------
module prq_dp #(
	parameter int                         DEPTH          = prq_pkg::DEPTH_DEFAULT,
	parameter logic [prq_pkg::RANK_W-1:0] EMPTY_SENTINEL = prq_pkg::EMPTY_SENTINEL_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  prq_pkg::prq_cmd_t                 cmd,
	input  logic [prq_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic [prq_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic [prq_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [prq_pkg::M_TUSER_W-1:0]     m_tuser,
	input  logic                              cfg_we,
	input  logic [prq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prq_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import prq_pkg::*;

	localparam int NC   = DEPTH + 1;
	localparam int CW   = $clog2(DEPTH + 2);
	localparam int CMPW = (CW > HL_W) ? CW : HL_W;

	logic [RANK_W-1:0]   rank_q   [NC];
	logic [HANDLE_W-1:0] handle_q [NC];
	logic [NC-1:0]       ins;
	logic [NC-1:0]       tail_oh;

	logic                op_q;
	logic [RANK_W-1:0]   in_rank_q;
	logic [HANDLE_W-1:0] in_handle_q;
	logic [CW-1:0]       count_q;
	logic                was_empty_q;
	logic [KIND_W-1:0]   kind_q;
	logic [RANK_W-1:0]   ret_rank_q;
	logic [HANDLE_W-1:0] ret_handle_q;
	logic [RANK_W-1:0]   max_q;
	logic [CNT32_W-1:0]  enq_q;
	logic [CNT32_W-1:0]  deq_q;
	logic [HL_W-1:0]     high_limit_q;
	logic                max_en_q;

	logic [RANK_W-1:0]   tail_rank;
	logic [HANDLE_W-1:0] tail_handle;
	logic                evict;
	logic [RANK_W-1:0]   max_nxt;
	logic                empty;

	logic [KIND_W-1:0]   o_kind_q;
	logic [HANDLE_W-1:0] o_handle_q;
	logic [RANK_W-1:0]   o_rank_q;
	logic [OCC_W-1:0]    o_occ_q;
	logic [RANK_W-1:0]   o_max_q;
	logic                o_hv_q;
	logic [RANK_W-1:0]   o_hr_q;
	logic [HANDLE_W-1:0] o_hh_q;
	logic [CNT32_W-1:0]  o_enq_q;
	logic [CNT32_W-1:0]  o_deq_q;

	assign empty = (count_q == '0);

	// insert point is a thermometer: every cell at or past it is marked
	always_comb begin
		tail_rank   = '0;
		tail_handle = '0;
		for (int i = 0; i < NC; i++) begin
			ins[i]     = (CW'(i) >= count_q) || (in_rank_q <= rank_q[i]);
			tail_oh[i] = (CW'(i + 1) == count_q);
			tail_rank   = tail_rank   | (rank_q[i]   & {RANK_W{tail_oh[i]}});
			tail_handle = tail_handle | (handle_q[i] & {HANDLE_W{tail_oh[i]}});
		end
	end

	assign evict = (!was_empty_q &&
			(CMPW'(count_q) > CMPW'(high_limit_q))) || (count_q > CW'(DEPTH));

	always_comb begin
		max_nxt = max_q;
		if (op_q == OP_PUSH) begin
			if (max_en_q) max_nxt = empty ? EMPTY_SENTINEL : tail_rank;
		end else if (kind_q == KIND_POP) begin
			if (empty) begin
				max_nxt = EMPTY_SENTINEL;
			end else if (max_en_q) begin
				max_nxt = tail_rank;
			end
		end
	end

	for (genvar g = 0; g < NC; g++) begin : g_cell
		logic                ins_prev;
		logic [RANK_W-1:0]   prev_rank;
		logic [HANDLE_W-1:0] prev_handle;
		logic [RANK_W-1:0]   next_rank;
		logic [HANDLE_W-1:0] next_handle;

		if (g == 0) begin : g_first
			assign ins_prev    = 1'b0;
			assign prev_rank   = in_rank_q;
			assign prev_handle = in_handle_q;
		end else begin : g_mid
			assign ins_prev    = ins[g-1];
			assign prev_rank   = rank_q[g-1];
			assign prev_handle = handle_q[g-1];
		end

		if (g == NC - 1) begin : g_last
			assign next_rank   = rank_q[g];
			assign next_handle = handle_q[g];
		end else begin : g_inner
			assign next_rank   = rank_q[g+1];
			assign next_handle = handle_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (op_q == OP_PUSH) begin
					if (ins[g]) begin
						if (ins_prev) begin
							rank_q[g]   <= prev_rank;
							handle_q[g] <= prev_handle;
						end else begin
							rank_q[g]   <= in_rank_q;
							handle_q[g] <= in_handle_q;
						end
					end
				end else if (!empty) begin
					rank_q[g]   <= next_rank;
					handle_q[g] <= next_handle;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q        <= s_tuser[0];
			in_rank_q   <= s_tdata[RANK_W-1:0];
			in_handle_q <= s_tdata[RANK_W +: HANDLE_W];
		end
		if (cmd.exec) begin
			was_empty_q <= empty;
			if (op_q == OP_POP && !empty) begin
				ret_rank_q   <= rank_q[0];
				ret_handle_q <= handle_q[0];
			end else begin
				ret_rank_q   <= '0;
				ret_handle_q <= '0;
			end
		end
		if (cmd.trim && op_q == OP_PUSH) begin
			if (evict) begin
				ret_rank_q   <= tail_rank;
				ret_handle_q <= tail_handle;
			end else begin
				ret_rank_q   <= '0;
				ret_handle_q <= '0;
			end
		end
		if (cmd.load_out) begin
			o_kind_q   <= kind_q;
			o_handle_q <= ret_handle_q;
			o_rank_q   <= ret_rank_q;
			o_occ_q    <= OCC_W'(count_q);
			o_max_q    <= max_nxt;
			o_hv_q     <= !empty;
			o_hr_q     <= empty ? '0 : rank_q[0];
			o_hh_q     <= empty ? '0 : handle_q[0];
			o_enq_q    <= enq_q;
			o_deq_q    <= deq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			kind_q       <= KIND_NONE;
			max_q        <= EMPTY_SENTINEL;
			enq_q        <= '0;
			deq_q        <= '0;
			high_limit_q <= HIGH_LIMIT_RESET;
			max_en_q     <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HIGH_LIMIT: high_limit_q <= cfg_data;
					REG_MAX_UPDATE: max_en_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				if (op_q == OP_PUSH) begin
					count_q <= count_q + 1'b1;
					enq_q   <= enq_q + 1'b1;
					kind_q  <= KIND_NONE;
				end else if (!empty) begin
					count_q <= count_q - 1'b1;
					deq_q   <= deq_q + 1'b1;
					kind_q  <= KIND_POP;
				end else begin
					kind_q  <= KIND_NONE;
				end
			end
			if (cmd.trim && op_q == OP_PUSH && evict) begin
				count_q <= count_q - 1'b1;
				deq_q   <= deq_q + 1'b1;
				kind_q  <= KIND_EVICT;
			end
			if (cmd.load_out) begin
				max_q <= max_nxt;
			end
		end
	end

	assign m_tuser = o_kind_q;
	assign m_tdata = {o_deq_q, o_enq_q, o_hh_q, o_hr_q, o_hv_q, o_max_q, o_occ_q,
			o_rank_q, o_handle_q};

endmodule

/* sv/pifo_rank_queue_with_eviction.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pifo_rank_queue_with_eviction
// Push-in first-out queue ordered by ascending rank, with tail eviction.
// ----------------------------------------------------------------------------
// Each item runs through four steps: latch at acceptance, parallel
// compare-and-shift over the row of DEPTH+1 rank cells, tail trim (eviction
// when occupancy exceeds high_limit unless the row was empty before the
// push, or when the row overflows), and result load. The next item can be
// accepted in the cycle after the load. The load, and with it the next
// acceptance, holds while an earlier result still waits unaccepted in the
// output register. The input reopens as soon as the result is loaded, even
// while that result still waits in the output register. Configuration writes
// are always taken and must only be issued while no item is in flight.
// ----------------------------------------------------------------------------
module pifo_rank_queue_with_eviction #(
	parameter int                         DEPTH          = prq_pkg::DEPTH_DEFAULT,
	parameter logic [prq_pkg::RANK_W-1:0] EMPTY_SENTINEL = prq_pkg::EMPTY_SENTINEL_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// rank[26:0], handle[42:27], zero pad [47:43]
	input  logic [prq_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode[0]
	input  logic [prq_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_handle[15:0], out_rank[42:16], occupancy[48:43], max_rank[75:49],
	// head_valid[76], head_rank[103:77], head_handle[119:104],
	// enqueue_count[151:120], dequeue_count[183:152]
	output logic [prq_pkg::M_TDATA_W-1:0]  m_tdata,
	// out_kind[1:0]
	output logic [prq_pkg::M_TUSER_W-1:0]  m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [prq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import prq_pkg::*;

	prq_cmd_t cmd;

	assign cfg_ready = 1'b1;

	prq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	prq_dp #(
		.DEPTH          (DEPTH),
		.EMPTY_SENTINEL (EMPTY_SENTINEL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
